>>> hdl/rsks_pkg.sv
package rsks_pkg;

    localparam int DEPTH      = 16;
    localparam int NAME_BYTES = 20;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;
    localparam logic [1:0] CMD_SEARCH = 2'd3;

    localparam logic [2:0] STATUS_PUSHED  = 3'd0;
    localparam logic [2:0] STATUS_RECORD  = 3'd1;
    localparam logic [2:0] STATUS_EMPTY   = 3'd2;
    localparam logic [2:0] STATUS_FULL    = 3'd3;
    localparam logic [2:0] STATUS_NOMATCH = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_OUT,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0] name_a;
        logic [63:0] name_b;
        logic [31:0] name_c;
        logic [7:0]  age;
        logic [15:0] rank;
    } record_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_ctrl_t;

    // Keep only the bytes of an 8-byte name part that lie inside the name.
    function automatic logic [63:0] name_mask(input int first_byte);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (first_byte + b < NAME_BYTES)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [63:0] MASK_A   = name_mask(0);
    localparam logic [63:0] MASK_B   = name_mask(8);
    localparam logic [63:0] MASK_C64 = name_mask(16);
    localparam logic [31:0] MASK_C   = MASK_C64[31:0];

endpackage

>>> hdl/record_stack_with_key_search.sv
// Push, and any other command on an empty store: one result, in the cycle after the transfer.
// Pop: one result, through the store read register and then the result register; busy in ST_POP_OUT.
// Dump and search: one record memory read per cycle, busy through ST_SCAN, ST_FLUSH and ST_FINISH,
// with the last result registered from ST_FINISH.
// Results are strobed by result_valid for one cycle each; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the store and idles the sequencer.
module record_stack_with_key_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [63:0] name_part_a,
    input  logic [63:0] name_part_b,
    input  logic [31:0] name_part_c,
    input  logic [7:0]  age,
    input  logic [15:0] rank,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [63:0] out_name_a,
    output logic [63:0] out_name_b,
    output logic [31:0] out_name_c,
    output logic [7:0]  out_age,
    output logic [15:0] out_rank,
    output logic        last
);

    localparam int CNT_W  = rsks_pkg::CNT_W;
    localparam int ADDR_W = rsks_pkg::ADDR_W;

    rsks_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]      fill_count_reg, fill_count_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [1:0]            cmd_reg;
    logic [7:0]            key_reg;
    logic                  data_valid_reg;
    logic                  pend_valid_reg, pend_valid_next;
    rsks_pkg::record_t     pend_rec_reg, pend_rec_next;

    logic                  result_valid_reg;
    logic [2:0]            status_reg;
    rsks_pkg::record_t     out_rec_reg;
    logic                  last_reg;

    logic                  emit_valid;
    logic [2:0]            emit_status;
    rsks_pkg::record_t     emit_rec;
    logic                  emit_last;

    rsks_pkg::store_ctrl_t store_ctrl;
    rsks_pkg::record_t     wr_rec;
    rsks_pkg::record_t     rd_rec;

    logic                  accept;
    logic                  is_empty;
    logic                  is_full;
    logic                  scan_last;
    logic                  match;
    logic [CNT_W-1:0]      pop_slot;

    assign busy      = (state_reg != rsks_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign is_empty  = (fill_count_reg == '0);
    assign is_full   = (fill_count_reg == CNT_W'(rsks_pkg::DEPTH));
    assign pop_slot  = fill_count_reg - CNT_W'(1);
    assign scan_last = (scan_cnt_reg == pop_slot);
    // Shared compare unit: dump takes every record, search only equal ages.
    assign match     = (cmd_reg == rsks_pkg::CMD_DUMP) || (rd_rec.age == key_reg);

    assign wr_rec.name_a = name_part_a & rsks_pkg::MASK_A;
    assign wr_rec.name_b = name_part_b & rsks_pkg::MASK_B;
    assign wr_rec.name_c = name_part_c & rsks_pkg::MASK_C;
    assign wr_rec.age    = age;
    assign wr_rec.rank   = rank;

    rsks_store u_store (
        .clk     (clk),
        .ctrl    (store_ctrl),
        .wr_data (wr_rec),
        .rd_data (rd_rec)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsks_pkg::ST_IDLE:
            begin
                if (accept && (cmd != rsks_pkg::CMD_PUSH) && !is_empty)
                begin
                    if (cmd == rsks_pkg::CMD_POP)
                    begin
                        state_next = rsks_pkg::ST_POP_OUT;
                    end
                    else
                    begin
                        state_next = rsks_pkg::ST_SCAN;
                    end
                end
            end
            rsks_pkg::ST_POP_OUT:
            begin
                state_next = rsks_pkg::ST_IDLE;
            end
            rsks_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = rsks_pkg::ST_FLUSH;
                end
            end
            rsks_pkg::ST_FLUSH:
            begin
                state_next = rsks_pkg::ST_FINISH;
            end
            rsks_pkg::ST_FINISH:
            begin
                state_next = rsks_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rsks_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        store_ctrl      = '0;
        fill_count_next = fill_count_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        emit_valid      = 1'b0;
        emit_status     = rsks_pkg::STATUS_RECORD;
        emit_rec        = '0;
        emit_last       = 1'b0;
        case (state_reg)
            rsks_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == rsks_pkg::CMD_PUSH)
                    begin
                        emit_valid = 1'b1;
                        emit_last  = 1'b1;
                        if (is_full)
                        begin
                            emit_status = rsks_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            emit_status        = rsks_pkg::STATUS_PUSHED;
                            store_ctrl.wr_en   = 1'b1;
                            store_ctrl.wr_addr = fill_count_reg[ADDR_W-1:0];
                            fill_count_next    = fill_count_reg + CNT_W'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        emit_valid  = 1'b1;
                        emit_last   = 1'b1;
                        emit_status = rsks_pkg::STATUS_EMPTY;
                    end
                    else if (cmd == rsks_pkg::CMD_POP)
                    begin
                        store_ctrl.rd_en   = 1'b1;
                        store_ctrl.rd_addr = pop_slot[ADDR_W-1:0];
                        fill_count_next    = pop_slot;
                    end
                    else
                    begin
                        scan_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            rsks_pkg::ST_POP_OUT:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                emit_rec   = rd_rec;
            end
            rsks_pkg::ST_SCAN, rsks_pkg::ST_FLUSH:
            begin
                if (state_reg == rsks_pkg::ST_SCAN)
                begin
                    store_ctrl.rd_en   = 1'b1;
                    store_ctrl.rd_addr = scan_cnt_reg[ADDR_W-1:0];
                    scan_cnt_next      = scan_cnt_reg + CNT_W'(1);
                end
                // Hold one match back so the final one can carry last.
                if (data_valid_reg && match)
                begin
                    if (pend_valid_reg)
                    begin
                        emit_valid = 1'b1;
                        emit_rec   = pend_rec_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_rec_next   = rd_rec;
                end
            end
            rsks_pkg::ST_FINISH:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                if (pend_valid_reg)
                begin
                    emit_rec = pend_rec_reg;
                end
                else
                begin
                    emit_status = rsks_pkg::STATUS_NOMATCH;
                end
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rsks_pkg::ST_IDLE;
            fill_count_reg   <= '0;
            scan_cnt_reg     <= '0;
            data_valid_reg   <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_count_reg   <= fill_count_next;
            scan_cnt_reg     <= scan_cnt_next;
            data_valid_reg   <= (state_reg == rsks_pkg::ST_SCAN);
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= age;
        end
        pend_rec_reg <= pend_rec_next;
        status_reg   <= emit_status;
        out_rec_reg  <= emit_rec;
        last_reg     <= emit_last;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_name_a   = out_rec_reg.name_a;
    assign out_name_b   = out_rec_reg.name_b;
    assign out_name_c   = out_rec_reg.name_c;
    assign out_age      = out_rec_reg.age;
    assign out_rank     = out_rec_reg.rank;
    assign last         = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(rsks_pkg::DEPTH))
        else $error("fill count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == rsks_pkg::CMD_PUSH) && !is_full)
        |=> (fill_count_reg == $past(fill_count_reg) + CNT_W'(1)))
        else $error("push did not grow the store");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result while still busy");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsks_pkg::ST_SCAN) |-> !is_empty)
        else $error("scan over an empty store");

endmodule

>>> hdl/rsks_store.sv
module rsks_store (
    input  logic                 clk,
    input  rsks_pkg::store_ctrl_t ctrl,
    input  rsks_pkg::record_t    wr_data,
    output rsks_pkg::record_t    rd_data
);

    rsks_pkg::record_t mem [rsks_pkg::DEPTH];
    rsks_pkg::record_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] name_a;
        logic [63:0] name_b;
        logic [31:0] name_c;
        logic [7:0]  age;
        logic [15:0] rank;
        logic        drain_first;
    } stack_req_t;

    typedef struct packed {
        logic [2:0]        status;
        rsks_pkg::record_t rec;
        logic              last;
    } reply_t;

    localparam int IDLE_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = rsks_pkg::CMD_PUSH;
    logic [63:0] name_part_a = '0;
    logic [63:0] name_part_b = '0;
    logic [31:0] name_part_c = '0;
    logic [7:0]  age = '0;
    logic [15:0] rank = '0;
    logic        result_valid;
    logic [2:0]  status;
    logic [63:0] out_name_a;
    logic [63:0] out_name_b;
    logic [31:0] out_name_c;
    logic [7:0]  out_age;
    logic [15:0] out_rank;
    logic        last;

    stack_req_t queued_cmds[$];
    reply_t     pending_replies[$];

    rsks_pkg::record_t shadow_rec[rsks_pkg::DEPTH];
    int                shadow_fill = 0;

    int mismatch_count = 0;
    int items_done = 0;
    int idle_cycles = 0;
    int issued = 0;
    int burst_left = 1;
    int gap_left = 0;

    record_stack_with_key_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .name_part_a  (name_part_a),
        .name_part_b  (name_part_b),
        .name_part_c  (name_part_c),
        .age          (age),
        .rank         (rank),
        .result_valid (result_valid),
        .status       (status),
        .out_name_a   (out_name_a),
        .out_name_b   (out_name_b),
        .out_name_c   (out_name_c),
        .out_age      (out_age),
        .out_rank     (out_rank),
        .last         (last)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 50)
        begin
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Apply one command to the shadow stack and queue the replies it must produce.
    task automatic predict_replies(input stack_req_t req);
        reply_t batch[$];
        reply_t r;
        r = '0;
        if (req.cmd == rsks_pkg::CMD_PUSH)
        begin
            if (shadow_fill == rsks_pkg::DEPTH)
            begin
                r.status = rsks_pkg::STATUS_FULL;
            end
            else
            begin
                shadow_rec[shadow_fill].name_a = req.name_a & rsks_pkg::MASK_A;
                shadow_rec[shadow_fill].name_b = req.name_b & rsks_pkg::MASK_B;
                shadow_rec[shadow_fill].name_c = req.name_c & rsks_pkg::MASK_C;
                shadow_rec[shadow_fill].age    = req.age;
                shadow_rec[shadow_fill].rank   = req.rank;
                shadow_fill++;
                r.status = rsks_pkg::STATUS_PUSHED;
            end
            batch.push_back(r);
        end
        else if (shadow_fill == 0)
        begin
            r.status = rsks_pkg::STATUS_EMPTY;
            batch.push_back(r);
        end
        else if (req.cmd == rsks_pkg::CMD_POP)
        begin
            shadow_fill--;
            r.status = rsks_pkg::STATUS_RECORD;
            r.rec = shadow_rec[shadow_fill];
            batch.push_back(r);
        end
        else
        begin
            r.status = rsks_pkg::STATUS_RECORD;
            for (int i = 0; i < shadow_fill; i++)
            begin
                if (req.cmd == rsks_pkg::CMD_DUMP || shadow_rec[i].age == req.age)
                begin
                    r.rec = shadow_rec[i];
                    batch.push_back(r);
                end
            end
            if (batch.size() == 0)
            begin
                r = '0;
                r.status = rsks_pkg::STATUS_NOMATCH;
                batch.push_back(r);
            end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
        begin
            pending_replies.push_back(batch[i]);
        end
    endtask

    function automatic stack_req_t make_req(input logic [1:0] op, input logic [7:0] key,
                                            input logic drain);
        stack_req_t r;
        r.cmd         = op;
        r.name_a      = {$urandom, $urandom};
        r.name_b      = {$urandom, $urandom};
        r.name_c      = $urandom;
        r.age         = key;
        r.rank        = 16'($urandom_range(0, 65535));
        r.drain_first = drain;
        return r;
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk)
    begin
        stack_req_t req;
        logic       next_start;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            next_start = start;
            if (start && !busy)
            begin
                issued++;
                next_start = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                              : $urandom_range(1, 4);
                end
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (queued_cmds.size() > 0 &&
                         (!queued_cmds[0].drain_first || issued == items_done))
                begin
                    req = queued_cmds.pop_front();
                    cmd         <= req.cmd;
                    name_part_a <= req.name_a;
                    name_part_b <= req.name_b;
                    name_part_c <= req.name_c;
                    age         <= req.age;
                    rank        <= req.rank;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Check the result strobed this cycle, then predict for the command transferred now.
    always @(posedge clk)
    begin
        reply_t     want;
        stack_req_t req;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_replies.size() == 0)
                begin
                    report_mismatch("unexpected result, status", 64'(status), '0);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (out_name_a !== want.rec.name_a)
                        report_mismatch("out_name_a", out_name_a, want.rec.name_a);
                    if (out_name_b !== want.rec.name_b)
                        report_mismatch("out_name_b", out_name_b, want.rec.name_b);
                    if (out_name_c !== want.rec.name_c)
                        report_mismatch("out_name_c", 64'(out_name_c), 64'(want.rec.name_c));
                    if (out_age !== want.rec.age)
                        report_mismatch("out_age", 64'(out_age), 64'(want.rec.age));
                    if (out_rank !== want.rec.rank)
                        report_mismatch("out_rank", 64'(out_rank), 64'(want.rec.rank));
                    if (last !== want.last)
                        report_mismatch("last", 64'(last), 64'(want.last));
                end
                if (last)
                    items_done <= items_done + 1;
            end
            if (start && !busy)
            begin
                req.cmd         = cmd;
                req.name_a      = name_part_a;
                req.name_b      = name_part_b;
                req.name_c      = name_part_c;
                req.age         = age;
                req.rank        = rank;
                req.drain_first = 1'b0;
                predict_replies(req);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        stack_req_t req;
        int         pick;
        int         push_pct;
        int         pop_pct;
        logic [7:0] key;
        logic       fill_phase[6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

        // Commands on an empty store.
        queued_cmds.push_back(make_req(rsks_pkg::CMD_POP, 8'd0, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_DUMP, 8'd0, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_SEARCH, 8'd0, 1'b0));
        // Extreme field values.
        req = make_req(rsks_pkg::CMD_PUSH, 8'hFF, 1'b0);
        req.name_a = '1;
        req.name_b = '1;
        req.name_c = '1;
        req.rank   = '1;
        queued_cmds.push_back(req);
        req = make_req(rsks_pkg::CMD_PUSH, 8'h00, 1'b0);
        req.name_a = '0;
        req.name_b = '0;
        req.name_c = '0;
        req.rank   = '0;
        queued_cmds.push_back(req);
        queued_cmds.push_back(make_req(rsks_pkg::CMD_DUMP, 8'd0, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_SEARCH, 8'hFF, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_SEARCH, 8'h5A, 1'b0));
        // Fill to the top, then push once more into a full store.
        for (int i = 0; i < rsks_pkg::DEPTH - 2; i++)
        begin
            queued_cmds.push_back(make_req(rsks_pkg::CMD_PUSH,
                                           (i % 3 == 0) ? 8'd0 : 8'd17, 1'b0));
        end
        queued_cmds.push_back(make_req(rsks_pkg::CMD_PUSH, 8'd3, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_DUMP, 8'd0, 1'b1));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_SEARCH, 8'd0, 1'b0));
        queued_cmds.push_back(make_req(rsks_pkg::CMD_POP, 8'd0, 1'b0));

        // Alternate fill-heavy and drain-heavy stretches so the store hits both ends.
        for (int seg = 0; seg < 6; seg++)
        begin
            push_pct = fill_phase[seg] ? 70 : 15;
            pop_pct  = fill_phase[seg] ? 10 : 55;
            for (int n = 0; n < 16; n++)
            begin
                pick = $urandom_range(0, 99);
                key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 3));
                req = make_req(rsks_pkg::CMD_SEARCH, key, $urandom_range(0, 19) == 0);
                if (pick < push_pct)
                    req.cmd = rsks_pkg::CMD_PUSH;
                else if (pick < push_pct + pop_pct)
                    req.cmd = rsks_pkg::CMD_POP;
                else if (pick < push_pct + pop_pct + 12)
                    req.cmd = rsks_pkg::CMD_DUMP;
                queued_cmds.push_back(req);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_cmds.size() != 0 || start || pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (rsks_pkg::DEPTH + 4) @(posedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("results never seen", '0, 64'(pending_replies.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> record_stack_with_key_search.f
hdl/rsks_pkg.sv
hdl/rsks_store.sv
hdl/record_stack_with_key_search.sv
verif/tb_top.sv
